/* hdl/bsm_pkg.sv */
// Shared definitions for the radix-2 Booth multiplier.
// Holds the Booth recoding type and function and the stream byte size.
// No dependencies.
package bsm_pkg;

  // Stream words are padded to whole bytes
  localparam int unsigned ByteW = 8;

  // Action chosen by one Booth bit pair
  typedef enum logic [1:0] {
    BoothNop,
    BoothAdd,
    BoothSub
  } booth_op_e;

  // Recode (current bit, previous bit) of the multiplier
  function automatic booth_op_e booth_recode(input logic cur, input logic prev);
    booth_op_e op;
    unique case ({cur, prev})
      2'b00:   op = BoothNop;
      2'b01:   op = BoothAdd;
      2'b10:   op = BoothSub;
      2'b11:   op = BoothNop;
      default: op = BoothNop;
    endcase
    return op;
  endfunction

endpackage

/* hdl/bsm_cell.sv */
// One Booth step of the multiplier chain: add, subtract or neither, then shift right.
// Holds one word in flight with its own valid bit and elastic handshake.
// Depends on bsm_pkg.
module bsm_cell #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // upstream side
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [WIDTH:0]   acc_i,     // accumulator with guard bit
  input  logic [WIDTH-1:0] mplier_i,  // multiplier / low product bits
  input  logic             prev_i,    // Booth bit below mplier_i[0]
  input  logic [WIDTH-1:0] mcand_i,
  // downstream side
  output logic             valid_o,
  input  logic             ready_i,
  output logic [WIDTH:0]   acc_o,
  output logic [WIDTH-1:0] mplier_o,
  output logic             prev_o,
  output logic [WIDTH-1:0] mcand_o
);

  bsm_pkg::booth_op_e op;
  logic [WIDTH:0]     mcand_x;
  logic [WIDTH:0]     sum;
  logic [WIDTH:0]     acc_d, acc_q;
  logic [WIDTH-1:0]   mplier_d, mplier_q;
  logic               prev_d, prev_q;
  logic [WIDTH-1:0]   mcand_q;
  logic               valid_q;
  logic               load;

  // Booth add/subtract on the guarded accumulator
  always_comb begin
    op      = bsm_pkg::booth_recode(mplier_i[0], prev_i);
    mcand_x = {mcand_i[WIDTH-1], mcand_i};
    unique case (op)
      bsm_pkg::BoothAdd: sum = acc_i + mcand_x;
      bsm_pkg::BoothSub: sum = acc_i - mcand_x;
      bsm_pkg::BoothNop: sum = acc_i;
      default:           sum = acc_i;
    endcase
  end

  // Arithmetic right shift of {acc, mplier, prev}
  always_comb begin
    acc_d    = {sum[WIDTH], sum[WIDTH:1]};
    mplier_d = {sum[0], mplier_i[WIDTH-1:1]};
    prev_d   = mplier_i[0];
  end

  // Stage takes a word when empty or when its word moves on
  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      acc_q    <= acc_d;
      mplier_q <= mplier_d;
      prev_q   <= prev_d;
      mcand_q  <= mcand_i;
    end
  end

  assign valid_o  = valid_q;
  assign acc_o    = acc_q;
  assign mplier_o = mplier_q;
  assign prev_o   = prev_q;
  assign mcand_o  = mcand_q;

endmodule

/* hdl/booth_signed_multiplier.sv */
// Signed radix-2 Booth multiplier: a chain of WIDTH step cells, one per multiplier bit,
// each holding one operand pair in flight. It accepts one operand pair per clock while the
// output is not stalled and returns the exact 2*WIDTH-bit signed product, registered in
// each cell of the chain in turn; the last cell drives the output word. Each cell has its own
// valid bit, so a stalled output only holds the words queued behind it while bubbles
// further up keep filling. The accumulator has a guard bit, so the most negative
// operands give exact products.
// Depends on bsm_pkg and bsm_cell.
module booth_signed_multiplier #(
  parameter int unsigned WIDTH = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  // operand stream
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // [WIDTH-1:0] multiplicand, [2*WIDTH-1:WIDTH] multiplier, rest zero
  input  logic [((2*WIDTH+bsm_pkg::ByteW-1)/bsm_pkg::ByteW)*bsm_pkg::ByteW-1:0] s_axis_tdata,
  // product stream
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // [2*WIDTH-1:0] product, rest zero
  output logic [((2*WIDTH+bsm_pkg::ByteW-1)/bsm_pkg::ByteW)*bsm_pkg::ByteW-1:0] m_axis_tdata
);

  localparam int unsigned ProdW = 2 * WIDTH;
  localparam int unsigned DataW = ((ProdW + bsm_pkg::ByteW - 1) / bsm_pkg::ByteW) *
                                  bsm_pkg::ByteW;

  // Links between cells: link k feeds cell k
  logic             valid_s  [WIDTH+1];
  logic             ready_s  [WIDTH+1];
  logic [WIDTH:0]   acc_s    [WIDTH+1];
  logic [WIDTH-1:0] mplier_s [WIDTH+1];
  logic             prev_s   [WIDTH+1];
  logic [WIDTH-1:0] mcand_s  [WIDTH+1];
  logic [ProdW-1:0] product;

  // Chain head: fresh operand pair, cleared accumulator
  assign valid_s[0]    = s_axis_tvalid;
  assign s_axis_tready = ready_s[0];
  assign acc_s[0]      = '0;
  assign mplier_s[0]   = s_axis_tdata[ProdW-1:WIDTH];
  assign prev_s[0]     = 1'b0;
  assign mcand_s[0]    = s_axis_tdata[WIDTH-1:0];

  for (genvar k = 0; k < WIDTH; k++) begin : g_cell
    bsm_cell #(
      .WIDTH (WIDTH)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (valid_s[k]),
      .ready_o  (ready_s[k]),
      .acc_i    (acc_s[k]),
      .mplier_i (mplier_s[k]),
      .prev_i   (prev_s[k]),
      .mcand_i  (mcand_s[k]),
      .valid_o  (valid_s[k+1]),
      .ready_i  (ready_s[k+1]),
      .acc_o    (acc_s[k+1]),
      .mplier_o (mplier_s[k+1]),
      .prev_o   (prev_s[k+1]),
      .mcand_o  (mcand_s[k+1])
    );
  end

  // Chain tail: product is the low accumulator bits over the shifted-out bits
  assign ready_s[WIDTH] = m_axis_tready;
  assign m_axis_tvalid  = valid_s[WIDTH];
  assign product        = {acc_s[WIDTH][WIDTH-1:0], mplier_s[WIDTH]};
  assign m_axis_tdata   = DataW'(product);

  // prev and mcand of the last link carry nothing further
  logic unused_tail;
  assign unused_tail = prev_s[WIDTH] ^ (^mcand_s[WIDTH]) ^ acc_s[WIDTH][WIDTH];

endmodule
